[sv/weno5_pkg.sv]
`timescale 1ns / 1ps
package weno5_pkg;
   localparam int SAMPLE_W     = 16;
   localparam int EPS_W        = 24;
   localparam int WEIGHT_POWER = 2;
   localparam int FILL_W       = 3;
   localparam int FILL_FULL    = 4;
   // stencil differences and candidate values
   localparam int D1_W   = SAMPLE_W + 3;
   localparam int D2_W   = SAMPLE_W + 4;
   localparam int N_W    = SAMPLE_W + 5;
   // smoothness sums
   localparam int SQ_W   = 2 * D2_W - 2;
   localparam int B_W    = SQ_W + 2;
   // weight ratio, unsigned q1.30
   localparam int FRAC_W = 30;
   localparam int Q_W    = FRAC_W + 1;
   localparam int U_W    = Q_W + 3;
   localparam int SUM_W  = U_W + 2;
   localparam int DEN_W  = SUM_W + 3;
   localparam int PROD_W = U_W + 1 + N_W;
   localparam int NUM_W  = PROD_W + 2;
   // final quotient bits, covers the unsaturated range
   localparam int FQ_W   = SAMPLE_W + 2;

   localparam logic [2:0] GAIN_0 = 3'd1;
   localparam logic [2:0] GAIN_1 = 3'd6;
   localparam logic [2:0] GAIN_2 = 3'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [N_W-1:0]      cand_type;
   typedef logic        [B_W-1:0]      smooth_type;
   typedef logic        [Q_W-1:0]      ratio_type;
endpackage

[sv/weno5_reconstruction.sv]
`timescale 1ns / 1ps
// throughput: one word per cycle while the output is not stalled, set by the
// one-bit-per-stage ratio and face dividers
// a stalled output word freezes the whole pipeline; nothing is dropped or repeated
// reset (synchronous, active high) clears the fill count, the window and all valid bits
// and sets epsilon to 17
module weno5_reconstruction (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_face_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_wdata
);
   localparam int Q_W    = weno5_pkg::Q_W;
   localparam int FILL_W = weno5_pkg::FILL_W;

   logic adv, accept, produce;
   logic [weno5_pkg::EPS_W-1:0] eps_ff;
   weno5_pkg::sample_type win_ff [4];
   weno5_pkg::sample_type a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_base;
   logic v0_ff;
   logic sm_valid;
   weno5_pkg::smooth_type beta [3];
   weno5_pkg::smooth_type beta_min;
   weno5_pkg::cand_type cand [3];
   weno5_pkg::ratio_type ratio [3];
   weno5_pkg::cand_type cd_ff [Q_W][3];
   logic [Q_W-1:0] vd_ff;
   logic bl_valid;
   weno5_pkg::sample_type face;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign csr_ready = 1'b1;

   // a new row restarts the fill count before this word is counted
   assign fill_base = req_first ? '0 : fill_ff;
   assign produce   = fill_base >= FILL_W'(weno5_pkg::FILL_FULL);
   assign fill_in   = produce ? fill_base : fill_base + FILL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= weno5_pkg::EPS_W'(17);
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            win_ff[k] <= '0;
         end
      end else if (accept) begin
         fill_ff   <= fill_in;
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= win_ff[3];
         win_ff[3] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= win_ff[0];
         b_ff <= win_ff[1];
         c_ff <= win_ff[2];
         d_ff <= win_ff[3];
         e_ff <= req_sample;
      end
   end

   weno5_smooth u_smooth (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .epsilon  (eps_ff),
      .in_valid (v0_ff),
      .a        (a_ff),
      .b        (b_ff),
      .c        (c_ff),
      .d        (d_ff),
      .e        (e_ff),
      .out_valid(sm_valid),
      .beta     (beta),
      .beta_min (beta_min),
      .cand     (cand)
   );

   for (genvar k = 0; k < 3; k++) begin : g_div
      weno5_ratio_div u_div (
         .clock(clock),
         .adv  (adv),
         .num  (beta_min),
         .den  (beta[k]),
         .ratio(ratio[k])
      );
   end

   // candidates and valid ride alongside the ratio dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else if (adv) begin
         vd_ff <= {vd_ff[Q_W-2:0], sm_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff[0] <= cand;
         for (int j = 1; j < Q_W; j++) begin
            cd_ff[j] <= cd_ff[j-1];
         end
      end
   end

   weno5_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (vd_ff[Q_W-1]),
      .ratio    (ratio),
      .cand     (cd_ff[Q_W-1]),
      .out_valid(bl_valid),
      .face     (face)
   );

   assign rsp_valid      = bl_valid;
   assign rsp_face_value = face;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(weno5_pkg::FILL_FULL))
      else $error("fill count past full window");

   a_first_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_first |=> fill_ff == FILL_W'(1))
      else $error("new row did not restart the window");

   a_entry_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(v0_ff) |-> $past(accept))
      else $error("pipeline entry without accepted word");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vd_ff) && $stable(fill_ff))
      else $error("pipeline moved while output stalled");
endmodule

[sv/weno5_smooth.sv]
`timescale 1ns / 1ps
module weno5_smooth (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic [weno5_pkg::EPS_W-1:0]    epsilon,
   input  logic                           in_valid,
   input  weno5_pkg::sample_type          a,
   input  weno5_pkg::sample_type          b,
   input  weno5_pkg::sample_type          c,
   input  weno5_pkg::sample_type          d,
   input  weno5_pkg::sample_type          e,
   output logic                           out_valid,
   output weno5_pkg::smooth_type          beta [3],
   output weno5_pkg::smooth_type          beta_min,
   output weno5_pkg::cand_type            cand [3]
);
   localparam int D1_W = weno5_pkg::D1_W;
   localparam int D2_W = weno5_pkg::D2_W;
   localparam int N_W  = weno5_pkg::N_W;
   localparam int SQ_W = weno5_pkg::SQ_W;
   localparam int B_W  = weno5_pkg::B_W;

   logic [3:0] v_ff;
   logic signed [D1_W-1:0] d1_ff [3];
   logic signed [D2_W-1:0] d2_ff [3];
   logic [SQ_W-1:0] sq1_ff [3], sq2_ff [3];
   logic [B_W-1:0]  eps12_ff;
   weno5_pkg::cand_type n1_ff [3], n2_ff [3], n3_ff [3], n4_ff [3];
   weno5_pkg::smooth_type bs_ff [3], bs4_ff [3], bmin_ff;
   weno5_pkg::smooth_type bs_in [3];
   logic signed [D1_W-1:0] sa1, sb1, sc1, sd1, se1;
   logic signed [D2_W-1:0] sa2, sb2, sc2, sd2, se2;
   logic signed [N_W-1:0]  sa3, sb3, sc3, sd3, se3;

   always_comb begin
      sa1 = D1_W'(a); sb1 = D1_W'(b); sc1 = D1_W'(c); sd1 = D1_W'(d); se1 = D1_W'(e);
      sa2 = D2_W'(a); sb2 = D2_W'(b); sc2 = D2_W'(c); sd2 = D2_W'(d); se2 = D2_W'(e);
      sa3 = N_W'(a);  sb3 = N_W'(b);  sc3 = N_W'(c);  sd3 = N_W'(d);  se3 = N_W'(e);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bs_in[k] = B_W'(sq1_ff[k]) * B_W'(13) + B_W'(sq2_ff[k]) * B_W'(3) + eps12_ff;
         if (bs_in[k] == '0) begin
            bs_in[k] = B_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // differences and candidate values of each stencil
         d1_ff[0] <= sa1 - (sb1 <<< 1) + sc1;
         d2_ff[0] <= sa2 - (sb2 <<< 2) + sc2 * D2_W'(3);
         d1_ff[1] <= sb1 - (sc1 <<< 1) + sd1;
         d2_ff[1] <= sb2 - sd2;
         d1_ff[2] <= sc1 - (sd1 <<< 1) + se1;
         d2_ff[2] <= sc2 * D2_W'(3) - (sd2 <<< 2) + se2;
         n1_ff[0] <= (sa3 <<< 1) - sb3 * N_W'(7) + sc3 * N_W'(11);
         n1_ff[1] <= sc3 * N_W'(5) - sb3 + (sd3 <<< 1);
         n1_ff[2] <= (sc3 <<< 1) + sd3 * N_W'(5) - se3;
         for (int k = 0; k < 3; k++) begin
            sq1_ff[k] <= SQ_W'(d1_ff[k] * d1_ff[k]);
            sq2_ff[k] <= SQ_W'(d2_ff[k] * d2_ff[k]);
            n2_ff[k]  <= n1_ff[k];
            n3_ff[k]  <= n2_ff[k];
            n4_ff[k]  <= n3_ff[k];
            bs_ff[k]  <= bs_in[k];
            bs4_ff[k] <= bs_ff[k];
         end
         eps12_ff <= B_W'(epsilon) * B_W'(12);
         bmin_ff  <= (bs_ff[0] <= bs_ff[1])
                   ? ((bs_ff[0] <= bs_ff[2]) ? bs_ff[0] : bs_ff[2])
                   : ((bs_ff[1] <= bs_ff[2]) ? bs_ff[1] : bs_ff[2]);
      end
   end

   assign out_valid = v_ff[3];
   assign beta      = bs4_ff;
   assign beta_min  = bmin_ff;
   assign cand      = n4_ff;
endmodule

[sv/weno5_ratio_div.sv]
`timescale 1ns / 1ps
module weno5_ratio_div (
   input  logic                  clock,
   input  logic                  adv,
   input  weno5_pkg::smooth_type num,
   input  weno5_pkg::smooth_type den,
   output weno5_pkg::ratio_type  ratio
);
   localparam int B_W = weno5_pkg::B_W;
   localparam int Q_W = weno5_pkg::Q_W;

   logic [B_W-1:0] rem_ff [Q_W];
   logic [B_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0] q_ff   [Q_W];

   // one quotient bit per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= (num >= den) ? num - den : num;
         q_ff[0]   <= Q_W'(num >= den);
         den_ff[0] <= den;
      end
   end

   for (genvar j = 1; j < Q_W; j++) begin : g_step
      logic [B_W:0] r2;
      logic         ge;
      always_comb begin
         r2 = {rem_ff[j-1], 1'b0};
         ge = r2 >= {1'b0, den_ff[j-1]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= ge ? B_W'(r2 - {1'b0, den_ff[j-1]}) : B_W'(r2);
            q_ff[j]   <= {q_ff[j-1][Q_W-2:0], ge};
            den_ff[j] <= den_ff[j-1];
         end
      end
   end

   assign ratio = q_ff[Q_W-1];
endmodule

[sv/weno5_blend.sv]
`timescale 1ns / 1ps
module weno5_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  weno5_pkg::ratio_type  ratio [3],
   input  weno5_pkg::cand_type   cand [3],
   output logic                  out_valid,
   output weno5_pkg::sample_type face
);
   localparam int PW     = weno5_pkg::WEIGHT_POWER;
   localparam int Q_W    = weno5_pkg::Q_W;
   localparam int U_W    = weno5_pkg::U_W;
   localparam int SUM_W  = weno5_pkg::SUM_W;
   localparam int DEN_W  = weno5_pkg::DEN_W;
   localparam int PROD_W = weno5_pkg::PROD_W;
   localparam int NUM_W  = weno5_pkg::NUM_W;
   localparam int FQ_W   = weno5_pkg::FQ_W;
   localparam int S_W    = weno5_pkg::SAMPLE_W;
   localparam int FRAC_W = weno5_pkg::FRAC_W;
   localparam int PRE    = PW + 4;
   localparam logic [FQ_W-1:0] POS_MAX = FQ_W'((1 << (S_W - 1)) - 1);
   localparam logic [FQ_W-1:0] NEG_MAX = FQ_W'(1 << (S_W - 1));

   // power chain: t_ff[0] holds the ratio, each next stage multiplies once more
   logic [Q_W-1:0] t_ff [PW];
   logic [Q_W-1:0] q_ff [PW];
   weno5_pkg::cand_type n_ff [PW + 2][3];
   logic [PRE-1:0] v_ff;
   logic [U_W-1:0] u_ff [3];
   logic signed [PROD_W-1:0] p_ff [3];
   logic [SUM_W-1:0] sum_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] x_ff [FQ_W + 1];
   logic [DEN_W-1:0] dd_ff [FQ_W + 1];
   logic [FQ_W-1:0]  fq_ff [FQ_W + 1];
   logic             neg_ff [FQ_W + 1];
   logic [FQ_W-1:0]  vd_ff;
   logic             out_v_ff;
   weno5_pkg::sample_type face_ff;
   logic [NUM_W-1:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         vd_ff    <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[PRE-2:0], in_valid};
         vd_ff    <= {vd_ff[FQ_W-2:0], v_ff[PRE-1]};
         out_v_ff <= vd_ff[FQ_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            n_ff[0][k] <= cand[k];
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_ratio
      logic [Q_W-1:0] tk_ff [PW];
      logic [Q_W-1:0] qk_ff [PW];
      for (genvar p = 0; p < PW; p++) begin : g_pow
         if (p == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (adv) begin
                  tk_ff[0] <= ratio[k];
               end
            end
         end else begin : g_mul
            logic [2*Q_W-1:0] prod;
            assign prod = (2*Q_W)'(g_ratio[k].tk_ff[p-1]) * (2*Q_W)'(qk_ff[p-1]);
            always_ff @(posedge clock) begin
               if (adv) begin
                  tk_ff[p] <= Q_W'(prod >> FRAC_W);
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            qk_ff[0] <= ratio[k];
            for (int p = 1; p < PW; p++) begin
               qk_ff[p] <= qk_ff[p-1];
            end
         end
      end
      if (k == 0) begin : g_tap
         assign t_ff = tk_ff;
         assign q_ff = qk_ff;
      end
   end

   for (genvar p = 1; p < PW + 2; p++) begin : g_cand
      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[p] <= n_ff[p-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff[0] <= U_W'(g_ratio[0].tk_ff[PW-1]) * U_W'(weno5_pkg::GAIN_0);
         u_ff[1] <= U_W'(g_ratio[1].tk_ff[PW-1]) * U_W'(weno5_pkg::GAIN_1);
         u_ff[2] <= U_W'(g_ratio[2].tk_ff[PW-1]) * U_W'(weno5_pkg::GAIN_2);
         for (int k = 0; k < 3; k++) begin
            p_ff[k] <= $signed({1'b0, u_ff[k]}) * n_ff[PW][k];
         end
         sum_ff <= SUM_W'(u_ff[0]) + SUM_W'(u_ff[1]) + SUM_W'(u_ff[2]);
         num_ff <= NUM_W'(p_ff[0]) + NUM_W'(p_ff[1]) + NUM_W'(p_ff[2]);
         den_ff <= DEN_W'(sum_ff) * DEN_W'(6);
      end
   end

   // round half away from zero: bias the magnitude by half the divisor
   assign mag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]   <= mag + NUM_W'(den_ff >> 1);
         dd_ff[0]  <= den_ff;
         fq_ff[0]  <= '0;
         neg_ff[0] <= num_ff[NUM_W-1];
      end
   end

   for (genvar j = 1; j <= FQ_W; j++) begin : g_div
      localparam int SH = FQ_W - j;
      logic [NUM_W-1:0] dsh;
      logic             ge;
      always_comb begin
         dsh = NUM_W'(dd_ff[j-1]) << SH;
         ge  = x_ff[j-1] >= dsh;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[j]   <= ge ? x_ff[j-1] - dsh : x_ff[j-1];
            fq_ff[j]  <= {fq_ff[j-1][FQ_W-2:0], ge};
            dd_ff[j]  <= dd_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (neg_ff[FQ_W]) begin
            face_ff <= (fq_ff[FQ_W] > NEG_MAX) ? S_W'(-NEG_MAX)
                                               : S_W'(-fq_ff[FQ_W]);
         end else begin
            face_ff <= (fq_ff[FQ_W] > POS_MAX) ? S_W'(POS_MAX) : S_W'(fq_ff[FQ_W]);
         end
      end
   end

   assign out_valid = out_v_ff;
   assign face      = face_ff;

   logic unused_taps;
   assign unused_taps = ^{t_ff[0], q_ff[0], n_ff[PW+1][0]};
endmodule
